// ===== design/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and tables for the pendulum swing-up step core.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int FRAC_BITS = 24;
  localparam int Q30_SHIFT = 30 - FRAC_BITS;

  // Q2.30 constants, rounded half up to the working format
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = PI_Q30 / 2;
  localparam longint CORDIC_K    = 64'sd652032874;
  localparam longint PI_F        = (PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
  localparam longint FIVE_PI_F   = (5 * PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
  localparam longint TWO_PI_F    = 2 * PI_F;
  localparam longint ONE_F       = 64'sd1 <<< FRAC_BITS;
  localparam longint ROT_MAX     = 64'sd549755813887;

  localparam int CORDIC_W     = 34;
  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);

  // angle reduction: subtract 2*pi scaled by 2^k, k from WRAP_TOP down to 0
  localparam int WRAP_TOP = 5;
  localparam int WRAP_W   = 36;
  localparam int WRAP_K_W = $clog2(WRAP_TOP + 1);

  typedef logic signed [26:0]         angle_t;
  typedef logic signed [31:0]         vel_t;
  typedef logic signed [25:0]         trig_t;
  typedef logic signed [CORDIC_W-1:0] cordic_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STEP_TIME, REG_GRAVITY_GAIN, REG_TORQUE_MAX, REG_VELOCITY_MAX,
    REG_UP_RANGE, REG_USE_OVER_ROT, REG_OVER_ROT_LIMIT
  } reg_idx_t;

  // torque actions
  localparam logic [1:0] ACT_NEG = 2'd0;
  localparam logic [1:0] ACT_POS = 2'd2;

  // result packing in out_tdata
  localparam int OUT_ANGLE_LSB  = 0;
  localparam int OUT_VEL_LSB    = 27;
  localparam int OUT_REWARD_LSB = 59;
  localparam int OUT_ABSORB_LSB = 85;
  localparam int OUT_UP_LSB     = 86;
  localparam int OUT_W          = 104;

  function automatic cordic_t atan_q30(input logic [ITER_W-1:0] i);
    cordic_t r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      default: r = cordic_t'(34'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage

// ===== design/psu_mul.sv =====
// ----------------------------------------------------------------------------
// psu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module psu_mul
  import psu_pkg::*;
(
  input  logic                clk,
  input  logic signed [31:0]  a,
  input  logic signed [25:0]  b,
  output logic signed [57:0]  p_r
);

  logic signed [57:0] p_nxt;

  assign p_nxt = 58'(a) * 58'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== design/psu_cordic.sv =====
// ----------------------------------------------------------------------------
// psu_cordic
// Rotation-mode CORDIC, one iteration per cycle, sine and cosine in Q.F.
// ----------------------------------------------------------------------------
module psu_cordic
  import psu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  angle_t angle,
  output logic   done_r,
  output trig_t  sin_r,
  output trig_t  cos_r
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_POST} cstate_t;

  cstate_t             state_r, state_nxt;
  cordic_t             x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic                neg_r, neg_nxt, done_nxt;
  logic [ITER_W-1:0]   i_r, i_nxt;
  trig_t               sin_nxt, cos_nxt;
  cordic_t             z0, dx, dy, xs, ys, xf, yf;

  function automatic trig_t clamp_one(input cordic_t v);
    trig_t r;
    if (v > cordic_t'(ONE_F))       r = trig_t'(ONE_F);
    else if (v < -cordic_t'(ONE_F)) r = -trig_t'(ONE_F);
    else                            r = trig_t'(v);
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    neg_nxt = neg_r; i_nxt = i_r;
    done_nxt = 1'b0;
    sin_nxt = sin_r; cos_nxt = cos_r;
    z0 = cordic_t'(angle) <<< Q30_SHIFT;
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    xs = neg_r ? -x_r : x_r;
    ys = neg_r ? -y_r : y_r;
    xf = (xs + cordic_t'(64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    yf = (ys + cordic_t'(64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          x_nxt = cordic_t'(CORDIC_K);
          y_nxt = '0;
          i_nxt = '0;
          // fold into [-pi/2, pi/2], negate at the end
          if (z0 > cordic_t'(HALF_PI_Q30)) begin
            z_nxt = z0 - cordic_t'(PI_Q30); neg_nxt = 1'b1;
          end else if (z0 < -cordic_t'(HALF_PI_Q30)) begin
            z_nxt = z0 + cordic_t'(PI_Q30); neg_nxt = 1'b1;
          end else begin
            z_nxt = z0; neg_nxt = 1'b0;
          end
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        if (!z_r[CORDIC_W-1]) begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - atan_q30(i_r);
        end else begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + atan_q30(i_r);
        end
        i_nxt = i_r + 1'b1;
        if (i_r == ITER_W'(CORDIC_ITERS - 1)) state_nxt = C_POST;
      end
      C_POST: begin
        cos_nxt   = clamp_one(xf);
        sin_nxt   = clamp_one(yf);
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    neg_r <= neg_nxt; i_r <= i_nxt;
    sin_r <= sin_nxt; cos_r <= cos_nxt;
  end

endmodule

// ===== design/pendulum_swing_up_step_core.sv =====
// ----------------------------------------------------------------------------
// pendulum_swing_up_step_core
// Fixed-point swing-up pendulum environment, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* : one transaction per item. in_tuser[0] = opcode (1 start, 0 step),
//    in_tdata = action [1:0], start_angle [28:2].
//  - out_*: one transaction per item: angle, velocity, reward, absorbing,
//    upright step count packed in out_tdata.
//  - cfg_*: register writes (index, data), always ready; write only while idle.
//  - in_tready is high only while the sequencer is idle; an item is worked on
//    alone. A start item runs one angle reduction. A step item runs two passes
//    of the 30-iteration CORDIC (sine of the old angle, cosine of the new one,
//    each with the done handshake), three products through the shared multiplier
//    and two angle reductions. With the over-rotation penalty active the cosine
//    pass is skipped.
//  - The result sits in an output register; while the receiver stalls, the
//    next item runs up to its final step and waits there, no input is taken.
//  - Reset (rst_n low, synchronous) returns the registers to their defaults
//    and the pendulum state to zero.
// ----------------------------------------------------------------------------
module pendulum_swing_up_step_core
  import psu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // action [1:0], start_angle [28:2]
  input  logic [0:0]        in_tuser,   // opcode [0]
  output logic              out_tvalid,
  input  logic              out_tready,
  // angle [26:0], angular_velocity [58:27], reward [84:59], absorbing [85],
  // upright_steps [101:86]
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_WRAP_FIX, S_SIN_WAIT, S_MUL1, S_MUL2, S_ACC, S_MUL3,
    S_TH_INIT, S_TH_DONE, S_D_DONE, S_COS_WAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {TGT_START, TGT_TH, TGT_D} tgt_t;

  typedef logic signed [WRAP_W-1:0] wide_t;

  // configuration
  logic [24:0] step_time_r;
  logic [30:0] gravity_gain_r, torque_max_r, velocity_max_r;
  logic [25:0] up_range_r;
  logic        use_or_r;
  logic [15:0] or_limit_r;

  // pendulum state
  angle_t              angle_r, angle_nxt, prev_r, prev_nxt;
  vel_t                vel_r, vel_nxt;
  logic signed [39:0]  rot_r, rot_nxt;
  logic                flag_r, flag_nxt;
  logic [15:0]         or_steps_r, or_steps_nxt, up_cnt_r, up_cnt_nxt;

  // sequencer
  state_t              state_r, state_nxt;
  tgt_t                tgt_r, tgt_nxt;
  logic [WRAP_K_W-1:0] k_r, k_nxt;
  wide_t               x_r, x_nxt, acc_r, acc_nxt;
  logic [1:0]          action_r, action_nxt;
  trig_t               s_r, s_nxt;
  vel_t                vnew_r, vnew_nxt;

  // result staging and output register
  trig_t               reward_r, reward_nxt;
  logic                absorb_r, absorb_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  // shared units
  logic signed [31:0]  mul_a;
  logic signed [25:0]  mul_b;
  logic signed [57:0]  mul_p;
  wide_t               mq;
  logic                cor_start, cor_done;
  trig_t               cor_sin, cor_cos;

  // scratch
  wide_t               step_m, torque, vsum, vmax_w, th_w, d_w;
  logic signed [40:0]  rsum;
  logic                in_acc;

  psu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  psu_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(angle_r),
    .done_r(cor_done), .sin_r(cor_sin), .cos_r(cor_cos)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // floored product in Q.F
  assign mq = wide_t'(mul_p >>> FRAC_BITS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL1:  begin mul_a = vel_r; mul_b = 26'(signed'({1'b0, step_time_r})); end
      S_MUL2:  begin mul_a = 32'(signed'({1'b0, gravity_gain_r})); mul_b = s_r; end
      S_MUL3:  begin mul_a = vnew_r; mul_b = 26'(signed'({1'b0, step_time_r})); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r; tgt_nxt = tgt_r; k_nxt = k_r; x_nxt = x_r;
    acc_nxt = acc_r; action_nxt = action_r; s_nxt = s_r; vnew_nxt = vnew_r;
    angle_nxt = angle_r; prev_nxt = prev_r; vel_nxt = vel_r; rot_nxt = rot_r;
    flag_nxt = flag_r; or_steps_nxt = or_steps_r; up_cnt_nxt = up_cnt_r;
    reward_nxt = reward_r; absorb_nxt = absorb_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    cor_start = 1'b0;

    step_m = wide_t'(TWO_PI_F) <<< k_r;
    case (action_r)
      ACT_NEG: torque = -wide_t'({1'b0, torque_max_r});
      ACT_POS: torque = wide_t'({1'b0, torque_max_r});
      default: torque = '0;
    endcase
    vsum   = wide_t'(vel_r) + acc_r;
    vmax_w = wide_t'({1'b0, velocity_max_r});
    th_w   = x_r - wide_t'(PI_F);
    d_w    = x_r - wide_t'(PI_F);
    rsum   = 41'(rot_r) + 41'(d_w);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          action_nxt = in_tdata[1:0];
          if (in_tuser[0]) begin
            x_nxt     = wide_t'(signed'(in_tdata[28:2])) + wide_t'(PI_F);
            k_nxt     = WRAP_K_W'(WRAP_TOP);
            tgt_nxt   = TGT_START;
            state_nxt = S_WRAP;
          end else begin
            cor_start = 1'b1;
            state_nxt = S_SIN_WAIT;
          end
        end
      end
      // reduce x into [0, 2*pi): after step k, |x| < 2*pi*2^k
      S_WRAP: begin
        if (x_r >= step_m)       x_nxt = x_r - step_m;
        else if (x_r < 0)        x_nxt = x_r + step_m;
        if (k_r == '0) state_nxt = S_WRAP_FIX;
        else           k_nxt = k_r - 1'b1;
      end
      S_WRAP_FIX: begin
        if (x_r < 0) x_nxt = x_r + wide_t'(TWO_PI_F);
        unique case (tgt_r)
          TGT_START: state_nxt = S_OUT;
          TGT_TH:    state_nxt = S_TH_DONE;
          default:   state_nxt = S_D_DONE;
        endcase
        if (tgt_r == TGT_START) begin
          // start item: x + 2*pi when negative, minus pi
          angle_nxt    = angle_t'((x_r < 0 ? x_r + wide_t'(TWO_PI_F) : x_r)
                                  - wide_t'(PI_F));
          prev_nxt     = angle_nxt;
          rot_nxt      = 40'(angle_nxt);
          vel_nxt      = '0;
          flag_nxt     = 1'b0;
          or_steps_nxt = '0;
          up_cnt_nxt   = '0;
          reward_nxt   = '0;
          absorb_nxt   = 1'b0;
        end
      end
      S_SIN_WAIT: begin
        if (cor_done) begin
          s_nxt     = cor_sin;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: begin
        acc_nxt   = torque - mq;          // dt * v
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + mq;             // gravity * sin
        vsum    = wide_t'(vel_r) + acc_r + mq;
        if (vsum > vmax_w)       vnew_nxt = vel_t'(vmax_w);
        else if (vsum < -vmax_w) vnew_nxt = vel_t'(-vmax_w);
        else                     vnew_nxt = vel_t'(vsum);
        state_nxt = S_MUL3;
      end
      S_MUL3: state_nxt = S_TH_INIT;
      S_TH_INIT: begin
        x_nxt     = wide_t'(angle_r) + mq + wide_t'(PI_F);
        k_nxt     = WRAP_K_W'(WRAP_TOP);
        tgt_nxt   = TGT_TH;
        state_nxt = S_WRAP;
      end
      S_TH_DONE: begin
        angle_nxt = angle_t'(th_w);
        vel_nxt   = vnew_r;
        if (th_w > wide_t'({1'b0, up_range_r}) || th_w < -wide_t'({1'b0, up_range_r}))
          up_cnt_nxt = '0;
        else if (up_cnt_r != 16'hFFFF)
          up_cnt_nxt = up_cnt_r + 1'b1;
        x_nxt     = th_w - wide_t'(prev_r) + wide_t'(PI_F);
        k_nxt     = WRAP_K_W'(WRAP_TOP);
        tgt_nxt   = TGT_D;
        state_nxt = S_WRAP;
      end
      S_D_DONE: begin
        if (rsum > 41'(ROT_MAX))              rot_nxt = 40'(ROT_MAX);
        else if (rsum < -41'(ROT_MAX) - 41'sd1) rot_nxt = 40'(-ROT_MAX - 1);
        else                                  rot_nxt = 40'(rsum);
        flag_nxt = flag_r || (rot_nxt > 40'(FIVE_PI_F)) ||
                   (rot_nxt < -40'(FIVE_PI_F));
        if (flag_nxt && or_steps_r != 16'hFFFF) or_steps_nxt = or_steps_r + 1'b1;
        prev_nxt   = angle_r;
        absorb_nxt = use_or_r && flag_nxt && (or_steps_nxt > or_limit_r);
        if (use_or_r && flag_nxt) begin
          reward_nxt = -trig_t'(ONE_F);
          state_nxt  = S_OUT;
        end else begin
          cor_start  = 1'b1;
          state_nxt  = S_COS_WAIT;
        end
      end
      S_COS_WAIT: begin
        if (cor_done) begin
          reward_nxt = cor_cos;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, up_cnt_r, absorb_r, reward_r, vel_r, angle_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      step_time_r    <= 25'd167772;
      gravity_gain_r <= 31'd164416717;
      torque_max_r   <= 31'd33554432;
      velocity_max_r <= 31'd1317679466;
      up_range_r     <= 26'd13176795;
      use_or_r       <= 1'b0;
      or_limit_r     <= 16'd100;
      angle_r        <= '0;
      prev_r         <= '0;
      vel_r          <= '0;
      rot_r          <= '0;
      flag_r         <= 1'b0;
      or_steps_r     <= '0;
      up_cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r     <= angle_nxt;
      prev_r      <= prev_nxt;
      vel_r       <= vel_nxt;
      rot_r       <= rot_nxt;
      flag_r      <= flag_nxt;
      or_steps_r  <= or_steps_nxt;
      up_cnt_r    <= up_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP_TIME:      step_time_r    <= cfg_data[24:0];
          REG_GRAVITY_GAIN:   gravity_gain_r <= cfg_data;
          REG_TORQUE_MAX:     torque_max_r   <= cfg_data;
          REG_VELOCITY_MAX:   velocity_max_r <= cfg_data;
          REG_UP_RANGE:       up_range_r     <= cfg_data[25:0];
          REG_USE_OVER_ROT:   use_or_r       <= cfg_data[0];
          REG_OVER_ROT_LIMIT: or_limit_r     <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    tgt_r      <= tgt_nxt;
    k_r        <= k_nxt;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    action_r   <= action_nxt;
    s_r        <= s_nxt;
    vnew_r     <= vnew_nxt;
    reward_r   <= reward_nxt;
    absorb_r   <= absorb_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/psu_checker.sv =====
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks for the pendulum swing-up step core.
// ----------------------------------------------------------------------------
module psu_checker
  import psu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // one item at a time: no new transaction right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a terminated episode always carries the penalty reward
  a_absorb_penalty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_ABSORB_LSB] |->
      out_tdata[OUT_ABSORB_LSB-1:OUT_REWARD_LSB] == 26'(-ONE_F))
    else $error("absorbing result without penalty reward");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind pendulum_swing_up_step_core psu_checker u_psu_checker (.*);
